@@ hdl/wspc_pkg.sv @@
package wspc_pkg;

    // ring and field sizes
    localparam int WINDOW_MAX = 1024;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W      = 11;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 26;
    localparam int TIE_W      = 24;

    // per-transaction control carried down the pipeline
    typedef struct packed {
        logic last;     // final sample of the stream
        logic use_old;  // window is full, oldest sample leaves the sum
        logic reach;    // this sample completes the first full window
        logic short_s;  // stream shorter than the window so far
        logic zero;     // no nonzero sample so far
    } t_ctrl;

    // window length as used: zero acts as one, large values clamp to the ring depth
    function automatic logic [LEN_W-1:0] eff_window(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] w;
        if (len == '0) begin
            w = LEN_W'(1);
        end else if (len > LEN_W'(WINDOW_MAX)) begin
            w = LEN_W'(WINDOW_MAX);
        end else begin
            w = len;
        end
        return w;
    endfunction

endpackage

@@ hdl/window_sum_peak_counter.sv @@
// window_sum_peak_counter
// Streams unsigned samples on the input channel (i_in_valid / o_in_ready,
// i_sample, i_last). The last window-length samples sit in a 1024-entry ring
// memory; a running window sum, the largest full-window sum and the number of
// windows that reached it are kept in registers. When a transaction with
// i_last set has passed through, one result appears on the output channel
// (o_out_valid / i_out_ready): peak sum, tie count (saturating), an all-zero
// flag and a short-stream flag. Then the stream state starts over.
// Throughput: one sample per cycle while o_in_ready is high, set by the single
// ring read and write that each sample needs. A result is valid once the last
// sample has passed ring read, sum update and peak compare. A configuration
// write clears the stream state; the user must write the window length through
// i_cfg_wr_en / i_cfg_data only while the block is idle (the block does not enforce this).
// Reset (synchronous, active low) sets the window length to one and clears
// all stream state; the ring memory is not cleared, and its read data are only
// used from entries written in the current stream.
// If a result is waiting and the receiver stalls, samples keep flowing until
// the next result reaches the last stage; then o_in_ready drops until the
// waiting result is taken.
module window_sum_peak_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [wspc_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [wspc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wspc_pkg::SUM_W-1:0]    o_peak_sum,
    output logic [wspc_pkg::TIE_W-1:0]    o_peak_windows,
    output logic                          o_all_zero,
    output logic                          o_short_stream
);
    import wspc_pkg::*;

    // ring memory
    logic [SAMPLE_W-1:0] r_ring [WINDOW_MAX];

    // front-end stream state
    logic [LEN_W-1:0]    r_w;
    logic [PTR_W-1:0]    r_ptr;
    logic [LEN_W-1:0]    r_fill;
    logic                r_seen;

    // stage 1: sample and ring read data
    logic                r_s1_valid;
    t_ctrl               r_s1_ctrl;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [SUM_W-1:0]    r_total;

    // stage 2: updated window sum
    logic                r_s2_valid;
    t_ctrl               r_s2_ctrl;
    logic [SUM_W-1:0]    r_s2_total;
    logic [SUM_W-1:0]    r_best;
    logic [TIE_W-1:0]    r_tie;

    // output register
    logic                r_out_valid;
    logic [SUM_W-1:0]    r_out_peak;
    logic [TIE_W-1:0]    r_out_ties;
    logic                r_out_zero;
    logic                r_out_short;

    logic                advance;
    logic                accept;
    t_ctrl               n_ctrl;
    logic [LEN_W-1:0]    n_fill;
    logic [PTR_W-1:0]    rd_idx;
    logic [SUM_W-1:0]    n_total;
    logic [SUM_W-1:0]    n_best;
    logic [TIE_W-1:0]    n_tie;

    // pipeline moves unless a result must land on a stalled output register
    assign advance    = !(r_s2_valid && r_s2_ctrl.last && r_out_valid && !i_out_ready);
    assign o_in_ready = advance;
    assign accept     = i_in_valid && advance;

    // front end: fill level, ring addresses, stream flags
    always_comb begin
        n_ctrl.use_old = (r_fill >= r_w);
        n_ctrl.reach   = (r_fill < r_w) && ((r_fill + LEN_W'(1)) == r_w);
        n_fill         = (r_fill < r_w) ? r_fill + LEN_W'(1) : r_fill;
        n_ctrl.short_s = (n_fill < r_w);
        n_ctrl.zero    = !(r_seen || (i_sample != '0));
        n_ctrl.last    = i_last;
        rd_idx         = r_ptr - r_w[PTR_W-1:0];
    end

    // ring memory, read before write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_ptr] <= i_sample;
            r_rd_data     <= r_ring[rd_idx];
            r_s1_sample   <= i_sample;
            r_s1_ctrl     <= n_ctrl;
        end
    end

    // front-end state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= LEN_W'(1);
            r_ptr  <= '0;
            r_fill <= '0;
            r_seen <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_w    <= eff_window(i_cfg_data);
            r_ptr  <= '0;
            r_fill <= '0;
            r_seen <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_ptr  <= '0;
                r_fill <= '0;
                r_seen <= 1'b0;
            end else begin
                r_ptr  <= r_ptr + PTR_W'(1);
                r_fill <= n_fill;
                r_seen <= !n_ctrl.zero;
            end
        end
    end

    // running window sum
    assign n_total = r_total + SUM_W'(r_s1_sample)
                   - (r_s1_ctrl.use_old ? SUM_W'(r_rd_data) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_total    <= '0;
            r_s2_valid <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_total <= '0;
        end else if (advance) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_total <= r_s1_ctrl.last ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_s2_total <= n_total;
            r_s2_ctrl  <= r_s1_ctrl;
        end
    end

    // peak compare and tie count
    always_comb begin
        n_best = r_best;
        n_tie  = r_tie;
        priority if (r_s2_ctrl.reach) begin
            n_best = r_s2_total;
            n_tie  = TIE_W'(1);
        end else if (r_s2_ctrl.use_old && (r_s2_total > r_best)) begin
            n_best = r_s2_total;
            n_tie  = TIE_W'(1);
        end else if (r_s2_ctrl.use_old && (r_s2_total == r_best) && (r_tie != '1)) begin
            n_tie  = r_tie + TIE_W'(1);
        end else begin
            n_tie  = r_tie;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_tie       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_best <= '0;
            r_tie  <= '0;
        end else begin
            if (advance && r_s2_valid) begin
                if (r_s2_ctrl.last) begin
                    r_best <= '0;
                    r_tie  <= '0;
                end else begin
                    r_best <= n_best;
                    r_tie  <= n_tie;
                end
            end
            // output valid: set by a finished stream, cleared when taken
            if (advance && r_s2_valid && r_s2_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid && r_s2_ctrl.last) begin
            r_out_zero  <= r_s2_ctrl.zero;
            r_out_short <= r_s2_ctrl.short_s;
            if (r_s2_ctrl.zero || r_s2_ctrl.short_s) begin
                r_out_peak <= '0;
                r_out_ties <= '0;
            end else begin
                r_out_peak <= n_best;
                r_out_ties <= n_tie;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_peak_sum     = r_out_peak;
    assign o_peak_windows = r_out_ties;
    assign o_all_zero     = r_out_zero;
    assign o_short_stream = r_out_short;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_w)
        else $error("fill level above window length");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && r_s2_valid && r_s2_ctrl.last))
        else $error("input stalled without a blocked result");

    a_short_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_short_stream || o_all_zero))
            |-> (o_peak_sum == '0 && o_peak_windows == '0))
        else $error("peak reported for short or all-zero stream");

    a_peak_ties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_short_stream && !o_all_zero) |-> (o_peak_windows != '0))
        else $error("full stream reported with no peak window");

endmodule
